### rtl/u8u16_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

  // result kinds as seen on the output channel
  typedef enum logic [1:0] {
    KIND_UNIT      = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_MALFORMED = 2'd2,
    KIND_NOROOM    = 2'd3
  } kind_t;

  // work queue between the decoder front and the emitter back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam int unsigned ACCUM_W = 21;

  localparam logic [15:0]        HI_SURR_BASE = 16'hd800;
  localparam logic [15:0]        LO_SURR_BASE = 16'hdc00;
  localparam logic [ACCUM_W-1:0] SUPP_BASE    = 21'h10000;

  // one decoded job: a status, a single code unit, or a surrogate pair
  typedef struct packed {
    kind_t       kind;
    logic        pair;
    logic [15:0] unit_hi;
    logic [15:0] unit_lo;
    logic [15:0] written;
  } job_t;

endpackage

`default_nettype wire

### rtl/u8u16_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// byte stream channel
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// code unit and status channel
interface u8u16_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] code_unit;
  logic [15:0] units_written;
  logic        last_of_run;

  modport source (output valid, output kind, output code_unit, output units_written,
                  output last_of_run, input ready);
  modport sink (input valid, input kind, input code_unit, input units_written,
                input last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/u8u16_front.sv
`timescale 1ns / 1ps
`default_nettype none

module u8u16_front #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  u8u16_byte_if.sink          utf8,
  input  wire logic [15:0]    max_units,
  output u8u16_pkg::job_t     job,
  output logic                job_valid,
  input  wire logic           job_ready
);

  localparam int unsigned EXT_W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 2;
  localparam int unsigned ACC_W = u8u16_pkg::ACCUM_W;

  logic [ACC_W-1:0]       accum;
  logic [ACC_W-1:0]       accum_next;
  logic [1:0]             pending;
  logic [1:0]             pending_next;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic                   halted;
  logic                   halted_next;

  logic             accept;
  logic [7:0]       b;
  logic             is_zero;
  logic [ACC_W-1:0] shifted;
  logic             emit_go;
  logic [ACC_W-1:0] emit_cp;
  logic             big;
  logic [ACC_W-1:0] supp_off;
  logic [15:0]      surr_hi;
  logic [15:0]      surr_lo;
  logic [EXT_W-1:0] cap_ext;
  logic [EXT_W-1:0] mu_ext;
  logic [EXT_W-1:0] lim_ext;
  logic [EXT_W-1:0] need_ext;
  logic             room;
  logic [15:0]      count16;

  assign utf8.ready = job_ready;
  assign accept     = utf8.valid && job_ready;
  assign b          = utf8.in_byte;
  assign is_zero    = (b == 8'd0);
  assign shifted    = {accum[ACC_W-7:0], b[5:0]};
  assign count16    = 16'(count);

  // surrogate split of the finished code point
  assign big      = (emit_cp[ACC_W-1:16] != '0);
  assign supp_off = emit_cp - u8u16_pkg::SUPP_BASE;
  assign surr_hi  = u8u16_pkg::HI_SURR_BASE | {5'b0, supp_off[20:10]};
  assign surr_lo  = u8u16_pkg::LO_SURR_BASE | {6'b0, supp_off[9:0]};

  // room check against the smaller of the register and the counter range
  assign cap_ext  = {{(EXT_W-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};
  assign mu_ext   = EXT_W'(max_units);
  assign lim_ext  = (mu_ext < cap_ext) ? mu_ext : cap_ext;
  assign need_ext = big ? EXT_W'(2) : EXT_W'(1);
  assign room     = (EXT_W'(count) + need_ext) <= lim_ext;

  // byte classification and string state update
  always_comb begin
    accum_next   = accum;
    pending_next = pending;
    count_next   = count;
    halted_next  = halted;
    job_valid    = 1'b0;
    job          = '0;
    emit_go      = 1'b0;
    emit_cp      = '0;
    if (accept) begin
      if (halted) begin
        if (is_zero) begin
          accum_next   = '0;
          pending_next = '0;
          count_next   = '0;
          halted_next  = 1'b0;
        end
      end else if (pending != 2'd0) begin
        if (is_zero) begin
          job_valid    = 1'b1;
          job.kind     = u8u16_pkg::KIND_MALFORMED;
          job.written  = count16;
          accum_next   = '0;
          pending_next = '0;
          count_next   = '0;
        end else if (b[7:6] != 2'b10) begin
          job_valid    = 1'b1;
          job.kind     = u8u16_pkg::KIND_MALFORMED;
          job.written  = count16;
          accum_next   = '0;
          pending_next = '0;
          halted_next  = 1'b1;
        end else begin
          accum_next   = shifted;
          pending_next = pending - 2'd1;
          if (pending == 2'd1) begin
            emit_go = 1'b1;
            emit_cp = shifted;
          end
        end
      end else if (is_zero) begin
        job_valid   = 1'b1;
        job.kind    = u8u16_pkg::KIND_DONE;
        job.written = count16;
        count_next  = '0;
      end else if (!b[7]) begin
        emit_go = 1'b1;
        emit_cp = ACC_W'(b);
      end else if (b[7:5] == 3'b110) begin
        accum_next   = ACC_W'(b[4:0]);
        pending_next = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        accum_next   = ACC_W'(b[3:0]);
        pending_next = 2'd2;
      end else begin
        accum_next   = ACC_W'(b[2:0]);
        pending_next = 2'd3;
      end
    end

    // a complete code point: emit its units or stop for lack of room
    if (emit_go) begin
      accum_next   = '0;
      pending_next = '0;
      job_valid    = 1'b1;
      if (!room) begin
        job.kind    = u8u16_pkg::KIND_NOROOM;
        job.written = count16;
        halted_next = 1'b1;
      end else begin
        job.kind    = u8u16_pkg::KIND_UNIT;
        job.pair    = big;
        job.unit_hi = big ? surr_hi : emit_cp[15:0];
        job.unit_lo = surr_lo;
        job.written = 16'(count + COUNT_WIDTH'(1));
        count_next  = count + (big ? COUNT_WIDTH'(2) : COUNT_WIDTH'(1));
      end
    end
  end

  // string state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      accum   <= '0;
      pending <= '0;
      count   <= '0;
      halted  <= 1'b0;
    end else begin
      accum   <= accum_next;
      pending <= pending_next;
      count   <= count_next;
      halted  <= halted_next;
    end
  end

endmodule

`default_nettype wire

### rtl/u8u16_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module u8u16_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire u8u16_pkg::job_t wr_job,
  input  wire logic            wr_valid,
  output logic                 wr_ready,
  output u8u16_pkg::job_t      rd_job,
  output logic                 rd_valid,
  input  wire logic            rd_ready
);

  localparam int unsigned DEPTH = u8u16_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = u8u16_pkg::QUEUE_PTR_W;

  u8u16_pkg::job_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (fill != (PTR_W+1)'(DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_job   = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + (PTR_W+1)'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - (PTR_W+1)'(1);
      end
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

endmodule

`default_nettype wire

### rtl/u8u16_back.sv
`timescale 1ns / 1ps
`default_nettype none

module u8u16_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire u8u16_pkg::job_t job,
  input  wire logic            job_valid,
  output logic                 job_ready,
  u8u16_result_if.source       utf16
);

  logic        out_valid;
  logic [1:0]  out_kind;
  logic [15:0] out_unit;
  logic [15:0] out_written;
  logic        out_last;
  logic        second_pending;
  logic [15:0] second_unit;
  logic [15:0] second_written;
  logic        load_ok;

  assign load_ok   = !out_valid || utf16.ready;
  assign job_ready = load_ok && !second_pending;

  assign utf16.valid         = out_valid;
  assign utf16.kind          = out_kind;
  assign utf16.code_unit     = out_unit;
  assign utf16.units_written = out_written;
  assign utf16.last_of_run   = out_last;

  // output control: second half of a pair goes before the next job
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      second_pending <= 1'b0;
    end else if (load_ok) begin
      if (second_pending) begin
        out_valid      <= 1'b1;
        second_pending <= 1'b0;
      end else begin
        out_valid      <= job_valid;
        second_pending <= job_valid && job.pair;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load_ok) begin
      if (second_pending) begin
        out_kind    <= u8u16_pkg::KIND_UNIT;
        out_unit    <= second_unit;
        out_written <= second_written;
        out_last    <= 1'b1;
      end else begin
        out_kind       <= job.kind;
        out_unit       <= job.unit_hi;
        out_written    <= job.written;
        out_last       <= !job.pair;
        second_unit    <= job.unit_lo;
        second_written <= job.written + 16'd1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/utf8_to_utf16_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// UTF-8 to UTF-16 decoder. Takes one UTF-8 byte per transaction on utf8 and
// gives UTF-16 code units and status results on utf16. A zero byte ends the
// string with a done result; a bad or zero continuation byte gives a malformed
// result, and a code point that would take the unit count past max_units gives
// a no-room result; after a malformed or no-room stop the remaining bytes up to
// the zero terminator give no result. A byte is taken every cycle as long as
// the four-entry job queue has space; each result is one output transaction,
// so a code point of 0x10000 and above (a surrogate pair) gives two results;
// the sustained rate is one result per cycle while utf16.ready is high, set by
// the single output register. The user writes max_units through max_units_we /
// max_units_wdata only while the block is idle; the block does not enforce it.
module utf8_to_utf16_decoder #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  u8u16_byte_if.sink       utf8,
  u8u16_result_if.source   utf16,
  input  wire logic        max_units_we,
  input  wire logic [15:0] max_units_wdata
);

  logic [15:0]       max_units;
  u8u16_pkg::job_t   front_job;
  logic              front_valid;
  logic              front_ready;
  u8u16_pkg::job_t   back_job;
  logic              back_valid;
  logic              back_ready;

  // unit limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_units <= 16'hffff;
    end else if (max_units_we) begin
      max_units <= max_units_wdata;
    end
  end

  u8u16_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .utf8      (utf8),
    .max_units (max_units),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  u8u16_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_job   (front_job),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_job   (back_job),
    .rd_valid (back_valid),
    .rd_ready (back_ready)
  );

  u8u16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .utf16     (utf16)
  );

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_PERIOD   = 12;
  localparam int IDLE_PCT     = 18;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_BYTES  = 325;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRINT_CAP    = 40;

  // one expected result on the utf16 channel
  typedef struct {
    u8u16_pkg::kind_t kind;
    logic [15:0]      unit;
    logic [15:0]      written;
    logic             last;
  } u16_result_t;

  logic        clk;
  logic        rst;
  logic        max_units_we;
  logic [15:0] max_units_wdata;

  u8u16_byte_if   utf8_bus ();
  u8u16_result_if utf16_bus ();

  utf8_to_utf16_decoder DUT (
    .clk             (clk),
    .rst             (rst),
    .utf8            (utf8_bus),
    .utf16           (utf16_bus),
    .max_units_we    (max_units_we),
    .max_units_wdata (max_units_wdata)
  );

  // decoder shadow state
  logic [15:0] max_units_shadow;
  logic [20:0] cp_accum;
  logic [1:0]  cont_left;
  logic [15:0] units_so_far;
  bit          stopped;

  u16_result_t expected_units[$];

  int  mismatches;
  int  results_checked;
  int  bytes_sent;
  int  cycle_count;
  int  hold_len;
  int  kinds_seen[4];
  bit  no_idle;

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_string_state();
    cp_accum     = '0;
    cont_left    = '0;
    units_so_far = '0;
    stopped      = 1'b0;
  endfunction

  function automatic void push_result(u8u16_pkg::kind_t k, logic [15:0] u, logic last);
    u16_result_t r;
    r.kind    = k;
    r.unit    = u;
    r.written = units_so_far;
    r.last    = last;
    expected_units.push_back(r);
  endfunction

  // one code point: one unit, a surrogate pair, or no room
  function automatic void emit_code_point(logic [20:0] cp);
    int          need;
    int          lim;
    logic [20:0] v;
    need      = (cp < u8u16_pkg::SUPP_BASE) ? 1 : 2;
    // a 16-bit count caps at 65535, which max_units never exceeds
    lim       = int'(max_units_shadow);
    cp_accum  = '0;
    cont_left = '0;
    if (int'(units_so_far) > lim || lim - int'(units_so_far) < need) begin
      stopped = 1'b1;
      push_result(u8u16_pkg::KIND_NOROOM, 16'h0000, 1'b1);
    end else if (need == 1) begin
      units_so_far++;
      push_result(u8u16_pkg::KIND_UNIT, cp[15:0], 1'b1);
    end else begin
      v = cp - u8u16_pkg::SUPP_BASE;
      units_so_far++;
      push_result(u8u16_pkg::KIND_UNIT, u8u16_pkg::HI_SURR_BASE | 16'(v >> 10), 1'b0);
      units_so_far++;
      push_result(u8u16_pkg::KIND_UNIT, u8u16_pkg::LO_SURR_BASE | {6'b0, v[9:0]}, 1'b1);
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    // absorbing until the terminator after a stop
    if (stopped) begin
      if (b == 8'h00) clear_string_state();
      return;
    end
    // continuation byte expected
    if (cont_left != 2'd0) begin
      if (b == 8'h00) begin
        push_result(u8u16_pkg::KIND_MALFORMED, 16'h0000, 1'b1);
        clear_string_state();
      end else if (b[7:6] != 2'b10) begin
        cp_accum  = '0;
        cont_left = '0;
        stopped   = 1'b1;
        push_result(u8u16_pkg::KIND_MALFORMED, 16'h0000, 1'b1);
      end else begin
        cp_accum = {cp_accum[14:0], b[5:0]};
        cont_left--;
        if (cont_left == 2'd0) emit_code_point(cp_accum);
      end
      return;
    end
    // lead byte
    if (b == 8'h00) begin
      push_result(u8u16_pkg::KIND_DONE, 16'h0000, 1'b1);
      clear_string_state();
    end else if (b < 8'h80) begin
      emit_code_point({13'b0, b});
    end else if (b[7:5] == 3'b110) begin
      cp_accum  = {16'b0, b[4:0]};
      cont_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      cp_accum  = {17'b0, b[3:0]};
      cont_left = 2'd2;
    end else begin
      // anything else, stray continuation included, leads four bytes
      cp_accum  = {18'b0, b[2:0]};
      cont_left = 2'd3;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driving and checking
  // ---------------------------------------------------------------------------

  function automatic bit roll_idle();
    return !no_idle && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // one byte transaction; valid stays high for a following byte
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (roll_idle()) begin
      utf8_bus.valid <= 1'b0;
      @(negedge clk);
    end
    utf8_bus.valid   <= 1'b1;
    utf8_bus.in_byte <= b;
    do @(posedge clk); while (!utf8_bus.ready);
    decode_byte(b);
    bytes_sent++;
  endtask

  // stop offering, wait out expected results and the pipeline
  task automatic drain_results();
    @(negedge clk);
    utf8_bus.valid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_units(input logic [15:0] value);
    drain_results();
    @(negedge clk);
    max_units_we    <= 1'b1;
    max_units_wdata <= value;
    @(negedge clk);
    max_units_we     <= 1'b0;
    max_units_shadow  = value;
  endtask

  task automatic send_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
  endtask

  // result receiver: random stalls, or a counted hold-off on request
  always @(negedge clk) begin
    if (hold_len > 0) begin
      utf16_bus.ready <= 1'b0;
      hold_len--;
    end else begin
      utf16_bus.ready <= !roll_idle();
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    u16_result_t want;
    if (!rst && utf16_bus.valid && utf16_bus.ready) begin
      results_checked++;
      kinds_seen[utf16_bus.kind]++;
      if (expected_units.size() == 0) begin
        report_mismatch("result with nothing expected, code_unit", utf16_bus.code_unit,
                        16'h0000);
      end else begin
        want = expected_units.pop_front();
        if (utf16_bus.kind !== want.kind)
          report_mismatch("kind", {14'b0, utf16_bus.kind}, {14'b0, want.kind});
        if (utf16_bus.code_unit !== want.unit)
          report_mismatch("code_unit", utf16_bus.code_unit, want.unit);
        if (utf16_bus.units_written !== want.written)
          report_mismatch("units_written", utf16_bus.units_written, want.written);
        if (utf16_bus.last_of_run !== want.last)
          report_mismatch("last_of_run", {15'b0, utf16_bus.last_of_run}, {15'b0, want.last});
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still expected", cycle_count,
             expected_units.size());
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // empty string, ascii top, two- and three-byte forms, lone surrogate value
  task automatic test_single_units();
    send_bytes('{8'h00, 8'h7f, 8'hc2, 8'h80, 8'hed, 8'ha0, 8'h80, 8'h00});
  endtask

  // 0xff leads four bytes; all-ones payload gives the widest pair
  task automatic test_surrogate_pairs();
    send_bytes('{8'hff, 8'hbf, 8'hbf, 8'hbf, 8'h00});
  endtask

  // bad continuation then absorb; stray continuation lead cut by a zero
  task automatic test_malformed();
    send_bytes('{8'hc2, 8'h41, 8'h00, 8'h80, 8'h80, 8'h00});
  endtask

  // no room for a single unit, for a pair, and an exact fit
  task automatic test_no_room();
    write_max_units(16'd0);
    send_bytes('{8'h41, 8'h41, 8'h00});
    write_max_units(16'd1);
    send_bytes('{8'hf0, 8'h90, 8'h80, 8'h80, 8'h00, 8'h41, 8'h00});
  endtask

  // limit dropped below the count in mid string
  task automatic test_limit_lowered();
    write_max_units(16'hffff);
    send_bytes('{8'h41, 8'h41});
    write_max_units(16'd1);
    send_bytes('{8'h41, 8'h00});
  endtask

  // receiver holds off while bytes keep coming, so the input stalls
  task automatic test_output_stall();
    write_max_units(16'hffff);
    hold_len = HOLD_CYCLES;
    repeat (24) send_byte(8'($urandom_range(8'h7f, 8'h01)));
    send_byte(8'h00);
  endtask

  // one character, mostly well formed, sometimes broken or noise
  task automatic send_random_char();
    int         sel;
    int         ncont;
    logic [7:0] lead;
    sel   = $urandom_range(99);
    ncont = 0;
    if (sel < 40) begin
      lead = 8'($urandom_range(8'h7f, 8'h01));
    end else if (sel < 60) begin
      lead  = {3'b110, 5'($urandom)};
      ncont = 1;
    end else if (sel < 80) begin
      lead  = {4'b1110, 4'($urandom)};
      ncont = 2;
    end else if (sel < 88) begin
      lead  = {5'b11110, 3'($urandom)};
      ncont = 3;
    end else if (sel < 95) begin
      lead  = $urandom_range(1) ? {5'b11111, 3'($urandom)} : {2'b10, 6'($urandom)};
      ncont = 3;
    end else begin
      lead  = 8'($urandom);
      ncont = $urandom_range(3);
    end
    send_byte(lead);
    for (int i = 0; i < ncont; i++) begin
      if ($urandom_range(99) < 3) send_byte(8'($urandom));
      else send_byte({2'b10, 6'($urandom)});
    end
  endtask

  task automatic send_random_string();
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
    repeat (len) send_random_char();
    send_byte(8'h00);
  endtask

  task automatic test_random_strings(input int n);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n) send_random_string();
  endtask

  // random strings under several limits; the last phase never idles
  task automatic test_random_phases();
    logic [15:0] limits[6];
    limits = '{16'hffff, 16'd5, 16'd0, 16'h0000, 16'd1, 16'hffff};
    limits[3] = 16'($urandom);
    for (int p = 0; p < 6; p++) begin
      write_max_units(limits[p]);
      no_idle = (p == 5);
      test_random_strings(PHASE_BYTES);
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst              = 1'b1;
    utf8_bus.valid   = 1'b0;
    utf8_bus.in_byte = 8'h00;
    utf16_bus.ready  = 1'b0;
    max_units_we     = 1'b0;
    max_units_wdata  = 16'h0000;
    mismatches       = 0;
    results_checked  = 0;
    bytes_sent       = 0;
    hold_len         = 0;
    no_idle          = 1'b0;
    kinds_seen       = '{0, 0, 0, 0};
    max_units_shadow = 16'hffff;
    clear_string_state();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_units();
    test_surrogate_pairs();
    test_malformed();
    test_no_room();
    test_limit_lowered();
    test_output_stall();
    test_random_phases();

    drain_results();
    if (expected_units.size() != 0)
      report_mismatch("results left over, count", 16'(expected_units.size()), 16'h0000);

    $display("sent %0d bytes, checked %0d results", bytes_sent, results_checked);
    $display("units %0d, done %0d, malformed %0d, no room %0d",
             kinds_seen[u8u16_pkg::KIND_UNIT], kinds_seen[u8u16_pkg::KIND_DONE],
             kinds_seen[u8u16_pkg::KIND_MALFORMED], kinds_seen[u8u16_pkg::KIND_NOROOM]);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### sim.f
rtl/u8u16_pkg.sv
rtl/u8u16_ifs.sv
rtl/u8u16_front.sv
rtl/u8u16_queue.sv
rtl/u8u16_back.sv
rtl/utf8_to_utf16_decoder.sv
tb/testbench.sv
